@@ rtl/core/rsi_pkg.sv @@
// ============================================================================
// rsi_pkg - shared definitions for the relative strength index block
// Default sizes, fixed constants, the control word format and the microcode
// program that drives the datapath.
// ============================================================================
package rsi_pkg;

    // Default sizes and fixed constants
    localparam int         PRICE_BITS_DEF = 32;
    localparam int         FRAC_BITS_DEF  = 16;
    localparam int         PERIOD_BITS    = 8;
    localparam logic [7:0] PERIOD_RESET   = 8'd6;
    localparam int         PCT_SCALE      = 100;
    // bits needed to hold the integer part of a percentage (0..100)
    localparam int         PCT_BITS       = 7;

    // Microcode address
    typedef logic [3:0] upc_t;

    localparam upc_t UPC_WAIT  = 4'd0;   // wait for an input transaction
    localparam upc_t UPC_CHECK = 4'd1;   // seed a new series, or carry on
    localparam upc_t UPC_LDG   = 4'd2;   // load divider for gain smoothing
    localparam upc_t UPC_DIVG  = 4'd3;   // divide |x - s| by n (gain)
    localparam upc_t UPC_UPG   = 4'd4;   // update gain, load move smoothing
    localparam upc_t UPC_DIVM  = 4'd5;   // divide |x - s| by n (move)
    localparam upc_t UPC_UPM   = 4'd6;   // update move and previous price
    localparam upc_t UPC_LDP   = 4'd7;   // load percentage divide, skip if flat
    localparam upc_t UPC_DIVP  = 4'd8;   // percentage divide
    localparam upc_t UPC_OUT   = 4'd9;   // hand result to output register
    localparam upc_t UPC_DONE  = 4'd10;  // back to wait

    // Divider load source
    typedef enum logic [1:0] {
        LD_NONE = 2'd0,
        LD_GAIN = 2'd1,
        LD_MOVE = 2'd2,
        LD_PCT  = 2'd3
    } ld_sel_t;

    // Smoothed value update target
    typedef enum logic [1:0] {
        UPD_NONE = 2'd0,
        UPD_GAIN = 2'd1,
        UPD_MOVE = 2'd2
    } upd_sel_t;

    // Jump conditions: taken means go to target, else fall through
    typedef enum logic [2:0] {
        JC_NEVER     = 3'd0,
        JC_NO_ACCEPT = 3'd1,
        JC_SEED      = 3'd2,
        JC_DIV_MORE  = 3'd3,
        JC_FLAT      = 3'd4,
        JC_OUT_BUSY  = 3'd5,
        JC_ALWAYS    = 3'd6
    } jcond_t;

    // One control word
    typedef struct packed {
        logic     take_in;   // input ready
        logic     seed_chk;  // seed the series when the seed condition holds
        ld_sel_t  ld;        // divider load
        logic     run;       // one divider iteration
        upd_sel_t upd;       // smoothed value update
        logic     put;       // write output register when free
        jcond_t   jc;        // jump condition
        upc_t     tgt;       // jump target
    } cw_t;

    localparam cw_t CW_NOP = '{
        take_in:  1'b0,
        seed_chk: 1'b0,
        ld:       LD_NONE,
        run:      1'b0,
        upd:      UPD_NONE,
        put:      1'b0,
        jc:       JC_NEVER,
        tgt:      UPC_WAIT
    };

    // Microcode program
    function automatic cw_t ucode_rom(input upc_t addr);
        cw_t cw;
        cw = CW_NOP;
        unique case (addr)
            UPC_WAIT: begin
                cw.take_in = 1'b1;
                cw.jc      = JC_NO_ACCEPT;
                cw.tgt     = UPC_WAIT;
            end
            UPC_CHECK: begin
                cw.seed_chk = 1'b1;
                cw.jc       = JC_SEED;
                cw.tgt      = UPC_WAIT;
            end
            UPC_LDG: begin
                cw.ld = LD_GAIN;
            end
            UPC_DIVG: begin
                cw.run = 1'b1;
                cw.jc  = JC_DIV_MORE;
                cw.tgt = UPC_DIVG;
            end
            UPC_UPG: begin
                cw.upd = UPD_GAIN;
                cw.ld  = LD_MOVE;
            end
            UPC_DIVM: begin
                cw.run = 1'b1;
                cw.jc  = JC_DIV_MORE;
                cw.tgt = UPC_DIVM;
            end
            UPC_UPM: begin
                cw.upd = UPD_MOVE;
            end
            UPC_LDP: begin
                cw.ld  = LD_PCT;
                cw.jc  = JC_FLAT;
                cw.tgt = UPC_OUT;
            end
            UPC_DIVP: begin
                cw.run = 1'b1;
                cw.jc  = JC_DIV_MORE;
                cw.tgt = UPC_DIVP;
            end
            UPC_OUT: begin
                cw.put = 1'b1;
                cw.jc  = JC_OUT_BUSY;
                cw.tgt = UPC_OUT;
            end
            default: begin
                cw.jc  = JC_ALWAYS;
                cw.tgt = UPC_WAIT;
            end
        endcase
        return cw;
    endfunction

endpackage

@@ rtl/core/relative_strength_index.sv @@
// ============================================================================
// relative_strength_index - Wilder style RSI over a stream of closing prices
// Smoothed gain and smoothed absolute move in fixed point, result as a
// percentage in fixed point, driven by a small microcoded sequencer.
// ============================================================================
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  s_      | in        | s_valid / s_ready   | s_close_price, s_first_of_series
//  m_      | out       | m_valid / m_ready   | m_rsi_value, m_flat_range
//  cfg_    | in        | cfg_wr_en, no wait  | cfg_wr_data (period)
//
//  Sequence: a seeding transaction only seeds the series; a scoring transaction
//  runs two smoothing divides of PRICE_BITS+FRAC_BITS steps and one percentage
//  divide of FRAC_BITS+7 steps on the single bit-serial divider, one quotient
//  bit a cycle, and skips the percentage divide when the range is flat. A new
//  price is taken only once the sequencer is back at its wait step.
//  Reset: synchronous, active low; clears period to 6 and the series state.
//  Stalls: the output register holds one result; the sequencer waits at its
//  output step only when that register is still full.
//
module relative_strength_index #(
    parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [rsi_pkg::PERIOD_BITS-1:0]   cfg_wr_data,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [PRICE_BITS-1:0]             s_close_price,
    input  logic                              s_first_of_series,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [FRAC_BITS+rsi_pkg::PCT_BITS-1:0] m_rsi_value,
    output logic                              m_flat_range
);

    localparam int ACC_BITS    = PRICE_BITS + FRAC_BITS;
    localparam int RSI_BITS    = FRAC_BITS + rsi_pkg::PCT_BITS;
    localparam int SCALED_BITS = ACC_BITS + rsi_pkg::PCT_BITS;
    localparam int CNT_BITS    = $clog2(ACC_BITS);
    localparam logic [RSI_BITS-1:0] RSI_MAX =
        RSI_BITS'(rsi_pkg::PCT_SCALE) << FRAC_BITS;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    rsi_pkg::upc_t                    upc_reg, upc_next;
    logic [rsi_pkg::PERIOD_BITS-1:0]  period_reg, period_next;
    logic [PRICE_BITS-1:0]            price_reg, price_next;
    logic                             first_reg, first_next;
    logic [PRICE_BITS-1:0]            prev_reg, prev_next;
    logic                             have_prev_reg, have_prev_next;
    logic [ACC_BITS-1:0]              sg_reg, sg_next;
    logic [ACC_BITS-1:0]              sm_reg, sm_next;
    logic [ACC_BITS-1:0]              div_rem_reg, div_rem_next;
    logic [ACC_BITS-1:0]              div_quo_reg, div_quo_next;
    logic [ACC_BITS-1:0]              div_den_reg, div_den_next;
    logic [CNT_BITS-1:0]              div_cnt_reg, div_cnt_next;
    logic                             div_neg_reg, div_neg_next;
    logic                             m_valid_reg, m_valid_next;
    logic [RSI_BITS-1:0]              m_value_reg, m_value_next;
    logic                             m_flat_reg, m_flat_next;

    // ------------------------------------------------------------------
    // Control word and datapath helpers
    // ------------------------------------------------------------------
    rsi_pkg::cw_t             cw;
    logic                     in_accept;
    logic                     seed;
    logic                     flat;
    logic                     out_free;
    logic                     jump;
    logic [PRICE_BITS-1:0]    diff;
    logic                     rising;
    logic [ACC_BITS-1:0]      gain_x, move_x;
    logic [ACC_BITS-1:0]      sel_x, sel_s;
    logic                     sel_neg;
    logic [ACC_BITS-1:0]      sel_d;
    logic [ACC_BITS-1:0]      upd_s;
    logic [ACC_BITS-1:0]      upd_step;
    logic [ACC_BITS-1:0]      upd_val;
    logic [ACC_BITS:0]        div_shift;
    logic                     div_fits;
    logic [ACC_BITS:0]        div_trial;
    logic [SCALED_BITS-1:0]   scaled;
    logic [ACC_BITS-1:0]      period_n;

    assign cw        = rsi_pkg::ucode_rom(upc_reg);
    assign s_ready   = cw.take_in;
    assign in_accept = s_valid && s_ready;
    assign seed      = first_reg || !have_prev_reg;
    assign flat      = (sm_reg == '0);
    assign out_free  = !m_valid_reg || m_ready;

    // Price change as gain and absolute move, in fixed point
    assign rising = (price_reg > prev_reg);
    assign diff   = rising ? (price_reg - prev_reg) : (prev_reg - price_reg);
    assign move_x = {diff, {FRAC_BITS{1'b0}}};
    assign gain_x = rising ? move_x : '0;

    // Smoothing operands: distance between new sample and running value
    always_comb begin
        if (cw.ld == rsi_pkg::LD_MOVE) begin
            sel_x = move_x;
            sel_s = sm_reg;
        end else begin
            sel_x = gain_x;
            sel_s = sg_reg;
        end
    end
    assign sel_neg = (sel_x < sel_s);
    assign sel_d   = sel_neg ? (sel_s - sel_x) : (sel_x - sel_s);

    // Smoothing update: s + floor(d/n), or s - ceil(d/n) when falling
    assign upd_s    = (cw.upd == rsi_pkg::UPD_MOVE) ? sm_reg : sg_reg;
    assign upd_step = div_quo_reg + ACC_BITS'(div_rem_reg != '0);
    assign upd_val  = div_neg_reg ? (upd_s - upd_step) : (upd_s + div_quo_reg);

    // Period zero acts as one
    assign period_n = (period_reg == '0) ? ACC_BITS'(1) : ACC_BITS'(period_reg);

    // Gain scaled by 100 for the percentage divide
    assign scaled = SCALED_BITS'(sg_reg) * SCALED_BITS'(rsi_pkg::PCT_SCALE);

    // Restoring divider: one quotient bit a cycle
    assign div_shift = {div_rem_reg, div_quo_reg[ACC_BITS-1]};
    assign div_fits  = (div_shift >= {1'b0, div_den_reg});
    assign div_trial = div_shift - {1'b0, div_den_reg};

    // Jump condition
    always_comb begin
        case (cw.jc)
            rsi_pkg::JC_NEVER:     jump = 1'b0;
            rsi_pkg::JC_NO_ACCEPT: jump = !s_valid;
            rsi_pkg::JC_SEED:      jump = seed;
            rsi_pkg::JC_DIV_MORE:  jump = (div_cnt_reg != '0);
            rsi_pkg::JC_FLAT:      jump = flat;
            rsi_pkg::JC_OUT_BUSY:  jump = !out_free;
            rsi_pkg::JC_ALWAYS:    jump = 1'b1;
            default:               jump = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        upc_next       = jump ? cw.tgt : upc_reg + rsi_pkg::upc_t'(1);
        period_next    = cfg_wr_en ? cfg_wr_data : period_reg;
        price_next     = price_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        sg_next        = sg_reg;
        sm_next        = sm_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_den_next   = div_den_reg;
        div_cnt_next   = div_cnt_reg;
        div_neg_next   = div_neg_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_value_next   = m_value_reg;
        m_flat_next    = m_flat_reg;

        // capture input transaction
        if (in_accept) begin
            price_next = s_close_price;
            first_next = s_first_of_series;
        end

        // start of a series: seed price, clear averages
        if (cw.seed_chk && seed) begin
            prev_next      = price_reg;
            have_prev_next = 1'b1;
            sg_next        = '0;
            sm_next        = '0;
        end

        // divider load
        case (cw.ld) inside
            rsi_pkg::LD_GAIN, rsi_pkg::LD_MOVE: begin
                div_rem_next = '0;
                div_quo_next = sel_d;
                div_den_next = period_n;
                div_neg_next = sel_neg;
                div_cnt_next = CNT_BITS'(ACC_BITS - 1);
            end
            rsi_pkg::LD_PCT: begin
                // top bits of 100*g are below the move, so start mid-division
                div_rem_next = scaled[SCALED_BITS-1:rsi_pkg::PCT_BITS];
                div_quo_next = {scaled[rsi_pkg::PCT_BITS-1:0],
                                {(ACC_BITS-rsi_pkg::PCT_BITS){1'b0}}};
                div_den_next = sm_reg;
                div_cnt_next = CNT_BITS'(RSI_BITS - 1);
            end
            default: ;
        endcase

        // divider iteration
        if (cw.run) begin
            div_rem_next = div_fits ? div_trial[ACC_BITS-1:0] : div_shift[ACC_BITS-1:0];
            div_quo_next = {div_quo_reg[ACC_BITS-2:0], div_fits};
            if (div_cnt_reg != '0) begin
                div_cnt_next = div_cnt_reg - CNT_BITS'(1);
            end
        end

        // smoothed value update
        case (cw.upd)
            rsi_pkg::UPD_GAIN: sg_next = upd_val;
            rsi_pkg::UPD_MOVE: begin
                sm_next   = upd_val;
                prev_next = price_reg;
            end
            default: ;
        endcase

        // result into output register
        if (cw.put && out_free) begin
            m_valid_next = 1'b1;
            m_flat_next  = flat;
            m_value_next = flat ? '0 : div_quo_reg[RSI_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Register update
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg       <= rsi_pkg::UPC_WAIT;
            period_reg    <= rsi_pkg::PERIOD_RESET;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            sg_reg        <= '0;
            sm_reg        <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            upc_reg       <= upc_next;
            period_reg    <= period_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            sg_reg        <= sg_next;
            sm_reg        <= sm_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        price_reg   <= price_next;
        first_reg   <= first_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_den_reg <= div_den_next;
        div_cnt_reg <= div_cnt_next;
        div_neg_reg <= div_neg_next;
        m_value_reg <= m_value_next;
        m_flat_reg  <= m_flat_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_rsi_value  = m_value_reg;
    assign m_flat_range = m_flat_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // both averages are settled, with gain at most move, while the sequencer waits for input
    a_gain_le_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == rsi_pkg::UPC_WAIT) |-> sg_reg <= sm_reg)
        else $error("smoothed gain above smoothed move");

    a_rsi_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_rsi_value <= RSI_MAX)
        else $error("result above one hundred percent");

    a_flat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_flat_range |-> m_rsi_value == '0)
        else $error("flat result with nonzero value");

    a_accept_check: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> upc_reg == rsi_pkg::UPC_CHECK)
        else $error("sequencer did not move to check after a transaction");

    a_put_written: assert property (@(posedge aclk) disable iff (!aresetn)
        cw.put && out_free |=> m_valid && m_flat_range == $past(flat))
        else $error("result not written to output register");

endmodule
